[rtl/iec_pkg.sv]
package iec_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int KEY_COUNT   = 128;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int KEY_AW      = $clog2(KEY_COUNT);
  localparam int POS_W       = 12;
  localparam int CFG_IW      = 1;

  localparam logic [POS_W-1:0] MAX_X_RST = POS_W'(1023);
  localparam logic [POS_W-1:0] MAX_Y_RST = POS_W'(767);
  localparam logic [POS_W-1:0] POS_X_RST = POS_W'(512);
  localparam logic [POS_W-1:0] POS_Y_RST = POS_W'(384);

  localparam logic [7:0] KEY_EVENT_TYPE = 8'd1;
  localparam logic [7:0] SC_RELEASE     = 8'h80;
  localparam logic [7:0] SC_KEY_MASK    = 8'h7F;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_SCAN  = 3'd1,
    OP_MOUSE = 3'd2,
    OP_POP   = 3'd3,
    OP_QUERY = 3'd4
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_MAX_X = 1'b0,
    REG_MAX_Y = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        push_type;
    logic [7:0]        push_code;
    logic [31:0]       push_value;
    logic [7:0]        scancode;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic [7:0]        buttons_in;
    logic [7:0]        query_key;
  } in_item_t;

  typedef struct packed {
    logic             pop_valid;
    logic [7:0]       event_type;
    logic [7:0]       event_code;
    logic [31:0]      event_value;
    logic             key_pressed;
    logic [POS_W-1:0] pointer_x;
    logic [POS_W-1:0] pointer_y;
    logic [7:0]       pointer_buttons;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IW-1:0] index;
    logic [POS_W-1:0]  data;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0]  ev_type;
    logic [7:0]  ev_code;
    logic [31:0] ev_value;
  } ev_entry_t;

  function automatic logic [Q_AW-1:0] next_slot(input logic [Q_AW-1:0] i);
    return (i == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [POS_W+1:0] v,
                                                 input logic [POS_W-1:0] hi);
    if (v < 0) begin
      return '0;
    end else if (v[POS_W:0] > {1'b0, hi}) begin
      return hi;
    end else begin
      return v[POS_W-1:0];
    end
  endfunction

endpackage

[rtl/iec_if.sv]
interface iec_in_if;
  import iec_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface iec_out_if;
  import iec_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface iec_cfg_if;
  import iec_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[rtl/input_event_controller_core.sv]
// An accepted input item and the event and key memory reads are registered;
// the modify/write-back step then loads the result into the output register.
// A new item is accepted only after the previous one has been written back.
// Output register decouples the result side; a stalled result holds the
// write-back cycle. Reset (rst_n, synchronous): empty queue, keys released,
// pointer 512/384, limits 1023/767; no memory clearing pass.
module input_event_controller_core (
  input  logic            clk,
  input  logic            rst_n,
  iec_in_if.sink          in_ch,
  iec_out_if.source       out_ch,
  iec_cfg_if.sink         cfg_ch
);
  import iec_pkg::*;

  ev_entry_t ev_mem [QUEUE_DEPTH];
  logic      key_mem [KEY_COUNT];

  state_t            state_r, state_nxt;
  in_item_t          item_r;
  ev_entry_t         ev_rd_r;
  logic              key_rd_r;
  logic [KEY_COUNT-1:0] key_vld_r, key_vld_nxt;
  logic [Q_AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [Q_AW-1:0]   wr_idx_r, wr_idx_nxt;
  logic [POS_W-1:0]  pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]  pos_y_r, pos_y_nxt;
  logic [7:0]        buttons_r, buttons_nxt;
  logic [POS_W-1:0]  max_x_r, max_y_r;
  logic              out_valid_r;
  out_item_t         out_item_r, res;

  logic              in_fire, exec_go, out_free;
  logic              ev_we;
  ev_entry_t         ev_wd;
  logic              key_we, key_wd;
  logic [KEY_AW-1:0] key_wa;
  logic [KEY_AW-1:0] key_ra;
  logic [6:0]        sc_key;
  logic              sc_press;
  logic              push_en;
  logic [Q_AW-1:0]   wr_adv;
  logic [KEY_AW-1:0] q_idx;
  logic signed [POS_W+1:0] nx, ny;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign key_ra   = in_ch.item.query_key[KEY_AW-1:0];
  assign cfg_ch.ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ch.ready = 1'b0;
    exec_go     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_EXEC: exec_go = out_free;
      default: ;
    endcase
  end

  // execute: modify and write back
  always_comb begin
    sc_key      = item_r.scancode[6:0] & SC_KEY_MASK[6:0];
    sc_press    = (item_r.scancode & SC_RELEASE) == 8'h00;
    push_en     = 1'b0;
    ev_wd       = '0;
    key_we      = 1'b0;
    key_wd      = sc_press;
    key_wa      = sc_key[KEY_AW-1:0];
    key_vld_nxt = key_vld_r;
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    buttons_nxt = buttons_r;
    q_idx       = item_r.query_key[KEY_AW-1:0];
    nx = $signed({2'b00, pos_x_r}) + (POS_W+2)'($signed(item_r.delta_x));
    ny = $signed({2'b00, pos_y_r}) - (POS_W+2)'($signed(item_r.delta_y));
    res = '0;
    case (op_t'(item_r.op))
      OP_PUSH: begin
        push_en = 1'b1;
        ev_wd   = '{ev_type: item_r.push_type, ev_code: item_r.push_code,
                    ev_value: item_r.push_value};
      end
      OP_SCAN: begin
        push_en = 1'b1;
        ev_wd   = '{ev_type: KEY_EVENT_TYPE, ev_code: {1'b0, sc_key},
                    ev_value: {31'd0, sc_press}};
        if ({1'b0, sc_key} < 8'(KEY_COUNT)) begin
          key_we = 1'b1;
          key_vld_nxt[key_wa] = 1'b1;
        end
      end
      OP_MOUSE: begin
        pos_x_nxt   = clamp_pos(nx, max_x_r);
        pos_y_nxt   = clamp_pos(ny, max_y_r);
        buttons_nxt = item_r.buttons_in;
      end
      OP_POP: begin
        if (rd_idx_r != wr_idx_r) begin
          res.pop_valid   = 1'b1;
          res.event_type  = ev_rd_r.ev_type;
          res.event_code  = ev_rd_r.ev_code;
          res.event_value = ev_rd_r.ev_value;
          rd_idx_nxt      = next_slot(rd_idx_r);
        end
      end
      OP_QUERY: begin
        if (item_r.query_key < 8'(KEY_COUNT)) begin
          res.key_pressed = key_vld_r[q_idx] & key_rd_r;
        end
      end
      default: ;
    endcase
    wr_adv = next_slot(wr_idx_r);
    if (push_en) begin
      wr_idx_nxt = wr_adv;
      if (wr_adv == rd_idx_r) rd_idx_nxt = next_slot(rd_idx_r);
    end
    ev_we = push_en;
    res.pointer_x       = pos_x_nxt;
    res.pointer_y       = pos_y_nxt;
    res.pointer_buttons = buttons_nxt;
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_rd_r  <= ev_mem[rd_idx_r];
      key_rd_r <= key_mem[key_ra];
    end
    if (exec_go && ev_we) ev_mem[wr_idx_r] <= ev_wd;
    if (exec_go && key_we) key_mem[key_wa] <= key_wd;
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_ch.item;
    if (exec_go) out_item_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_vld_r   <= '0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      pos_x_r     <= POS_X_RST;
      pos_y_r     <= POS_Y_RST;
      buttons_r   <= '0;
      max_x_r     <= MAX_X_RST;
      max_y_r     <= MAX_Y_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        key_vld_r <= key_vld_nxt;
        rd_idx_r  <= rd_idx_nxt;
        wr_idx_r  <= wr_idx_nxt;
        pos_x_r   <= pos_x_nxt;
        pos_y_r   <= pos_y_nxt;
        buttons_r <= buttons_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        unique case (reg_idx_t'(cfg_ch.item.index))
          REG_MAX_X: max_x_r <= cfg_ch.item.data;
          REG_MAX_Y: max_y_r <= cfg_ch.item.data;
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

endmodule
